// ===== rtl/l2k_pkg.sv =====
// l2k_pkg.sv: shared constants, types and beat/command structs for the top-k distance block
package l2k_pkg;

  localparam int VECTOR_DIM   = 128;
  localparam int BEST_COUNT   = 10;
  localparam int ELEMENT_BITS = 16;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 7;
  localparam int VAL_W  = 16;
  localparam int ID_W   = 32;
  localparam int RANK_W = 6;
  localparam int DIST_W = 48;

  localparam int ADDR_W = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
  localparam int LIST_W = (BEST_COUNT > 1) ? $clog2(BEST_COUNT) : 1;
  localparam int CNT_W  = $clog2(BEST_COUNT + 1);
  localparam int MAG_W  = ELEMENT_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [ID_W-1:0]                id_t;
  typedef logic [DIST_W-1:0]              dist_t;
  typedef logic [RANK_W-1:0]              rank_t;
  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic [LIST_W-1:0]              list_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic signed [ELEMENT_BITS:0]   diff_t;
  typedef logic [MAG_W-1:0]               mag_t;
  typedef logic [SQ_W-1:0]                sq_t;
  typedef logic [SUM_W-1:0]               sum_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CAND   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    idx_t                    element_index;
    logic signed [VAL_W-1:0] element_value;
    id_t                     candidate_id;
  } in_beat_t;

  typedef struct packed {
    rank_t rank;
    logic  slot_valid;
    id_t   result_id;
    dist_t result_distance;
    logic  last_result;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic ram_we;
    logic cap;
    logic diff_en;
    logic mul_en;
    logic acc_en;
    logic append;
    logic scan_clr;
    logic worst_step;
    logic repl;
    logic pick_clr;
    logic pick_step;
    logic show;
    logic next_rank;
    logic finish_clr;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic is_last;
    logic list_full;
    logic scan_last;
    logic rank_last;
  } dp_sts_t;

endpackage

// ===== rtl/l2k_ram.sv =====
// l2k_ram.sv: generic simple dual-port RAM with registered read
module l2k_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/l2k_ctrl.sv =====
// l2k_ctrl.sv: sequencer for query load, distance accumulation, list update and sorted emit
module l2k_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [l2k_pkg::CMD_W-1:0] in_cmd,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output l2k_pkg::dp_cmd_t         dp_cmd,
  input  l2k_pkg::dp_sts_t         dp_sts
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIFF = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_SCAN = 8'b0001_0000,
    S_REPL = 8'b0010_0000,
    S_PICK = 8'b0100_0000,
    S_SHOW = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    dp_cmd        = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == l2k_pkg::CMD_LOAD) begin
            dp_cmd.ram_we = dp_sts.in_range;
          end else if (in_cmd == l2k_pkg::CMD_CAND && dp_sts.in_range) begin
            dp_cmd.cap = 1'b1;
            state_nxt  = S_DIFF;
          end else if (in_cmd == l2k_pkg::CMD_FINISH) begin
            dp_cmd.pick_clr = 1'b1;
            state_nxt       = S_PICK;
          end
        end
      end
      S_DIFF: begin
        dp_cmd.diff_en = 1'b1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        dp_cmd.mul_en = 1'b1;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        dp_cmd.acc_en = 1'b1;
        if (dp_sts.is_last && dp_sts.list_full) begin
          dp_cmd.scan_clr = 1'b1;
          state_nxt       = S_SCAN;
        end else begin
          dp_cmd.append = dp_sts.is_last;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        dp_cmd.worst_step = 1'b1;
        if (dp_sts.scan_last) begin
          state_nxt = S_REPL;
        end
      end
      S_REPL: begin
        dp_cmd.repl = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_PICK: begin
        dp_cmd.pick_step = 1'b1;
        if (dp_sts.scan_last) begin
          state_nxt = S_SHOW;
        end
      end
      S_SHOW: begin
        // wait for the output register to be free
        if (out_free) begin
          dp_cmd.show   = 1'b1;
          out_valid_nxt = 1'b1;
          if (dp_sts.rank_last) begin
            dp_cmd.finish_clr = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            dp_cmd.next_rank = 1'b1;
            state_nxt        = S_PICK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/l2k_dp.sv =====
// l2k_dp.sv: query store, squared-distance pipeline, best list and output register
module l2k_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  l2k_pkg::in_beat_t    in_beat,
  input  l2k_pkg::dp_cmd_t     dp_cmd,
  output l2k_pkg::dp_sts_t     dp_sts,
  output l2k_pkg::out_beat_t   out_beat
);

  l2k_pkg::addr_t in_addr;
  logic [l2k_pkg::ELEMENT_BITS-1:0] ram_rdata;

  l2k_pkg::idx_t  idx_r, idx_nxt;
  l2k_pkg::elem_t val_r, val_nxt;
  l2k_pkg::id_t   id_r, id_nxt;
  l2k_pkg::mag_t  mag_r, mag_nxt;
  l2k_pkg::sq_t   sq_r, sq_nxt;
  l2k_pkg::dist_t acc_r, acc_nxt;
  l2k_pkg::dist_t cand_dist_r, cand_dist_nxt;
  l2k_pkg::cnt_t  fill_r, fill_nxt;
  l2k_pkg::list_t scan_r, scan_nxt;
  l2k_pkg::list_t worst_idx_r, worst_idx_nxt;
  l2k_pkg::dist_t worst_dist_r, worst_dist_nxt;
  logic           sel_found_r, sel_found_nxt;
  l2k_pkg::list_t sel_idx_r, sel_idx_nxt;
  l2k_pkg::dist_t sel_dist_r, sel_dist_nxt;
  l2k_pkg::id_t   sel_id_r, sel_id_nxt;
  logic [l2k_pkg::BEST_COUNT-1:0] emitted_r, emitted_nxt;
  l2k_pkg::list_t rank_r, rank_nxt;
  l2k_pkg::out_beat_t out_beat_r, out_beat_nxt;

  l2k_pkg::dist_t ent_dist_r [l2k_pkg::BEST_COUNT];
  l2k_pkg::id_t   ent_id_r   [l2k_pkg::BEST_COUNT];

  logic           wr_en;
  l2k_pkg::list_t wr_idx;
  l2k_pkg::dist_t wr_dist;
  l2k_pkg::id_t   wr_id;

  l2k_pkg::diff_t diff;
  l2k_pkg::dist_t acc_base;
  l2k_pkg::sum_t  acc_sum;
  l2k_pkg::dist_t new_acc;
  l2k_pkg::dist_t rd_dist;
  l2k_pkg::id_t   rd_id;
  logic           ent_ok;
  logic           ent_better;

  assign in_addr = l2k_pkg::addr_t'(in_beat.element_index);

  l2k_ram #(
    .WIDTH (l2k_pkg::ELEMENT_BITS),
    .DEPTH (l2k_pkg::VECTOR_DIM)
  ) u_query_ram (
    .clk   (clk),
    .we    (dp_cmd.ram_we),
    .waddr (in_addr),
    .wdata (in_beat.element_value[l2k_pkg::ELEMENT_BITS-1:0]),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign dp_sts.in_range  = int'(in_beat.element_index) < l2k_pkg::VECTOR_DIM;
  assign dp_sts.is_last   = int'(idx_r) == l2k_pkg::VECTOR_DIM - 1;
  assign dp_sts.list_full = fill_r == l2k_pkg::cnt_t'(l2k_pkg::BEST_COUNT);
  assign dp_sts.scan_last = scan_r == l2k_pkg::list_t'(l2k_pkg::BEST_COUNT - 1);
  assign dp_sts.rank_last = rank_r == l2k_pkg::list_t'(l2k_pkg::BEST_COUNT - 1);

  assign diff = l2k_pkg::diff_t'(val_r) - l2k_pkg::diff_t'(l2k_pkg::elem_t'(ram_rdata));

  // index 0 restarts the sum; saturate at the top of the distance range
  assign acc_base = (idx_r == '0) ? '0 : acc_r;
  assign acc_sum  = l2k_pkg::sum_t'(acc_base) + l2k_pkg::sum_t'(sq_r);
  assign new_acc  = (|acc_sum[l2k_pkg::SUM_W-1:l2k_pkg::DIST_W]) ? '1 :
                    acc_sum[l2k_pkg::DIST_W-1:0];

  assign rd_dist = ent_dist_r[scan_r];
  assign rd_id   = ent_id_r[scan_r];

  // smallest (distance, id) among entries not yet emitted
  assign ent_ok     = (l2k_pkg::cnt_t'(scan_r) < fill_r) && !emitted_r[scan_r];
  assign ent_better = !sel_found_r || (rd_dist < sel_dist_r) ||
                      ((rd_dist == sel_dist_r) && (rd_id < sel_id_r));

  always_comb begin
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    id_nxt         = id_r;
    mag_nxt        = mag_r;
    sq_nxt         = sq_r;
    acc_nxt        = acc_r;
    cand_dist_nxt  = cand_dist_r;
    fill_nxt       = fill_r;
    scan_nxt       = scan_r;
    worst_idx_nxt  = worst_idx_r;
    worst_dist_nxt = worst_dist_r;
    sel_found_nxt  = sel_found_r;
    sel_idx_nxt    = sel_idx_r;
    sel_dist_nxt   = sel_dist_r;
    sel_id_nxt     = sel_id_r;
    emitted_nxt    = emitted_r;
    rank_nxt       = rank_r;
    out_beat_nxt   = out_beat_r;
    wr_en          = 1'b0;
    wr_idx         = worst_idx_r;
    wr_dist        = cand_dist_r;
    wr_id          = id_r;

    if (dp_cmd.cap) begin
      idx_nxt = in_beat.element_index;
      val_nxt = l2k_pkg::elem_t'(in_beat.element_value);
      id_nxt  = in_beat.candidate_id;
    end
    if (dp_cmd.diff_en) begin
      mag_nxt = diff[l2k_pkg::ELEMENT_BITS] ? l2k_pkg::mag_t'(-diff) : l2k_pkg::mag_t'(diff);
    end
    if (dp_cmd.mul_en) begin
      sq_nxt = l2k_pkg::sq_t'(mag_r) * l2k_pkg::sq_t'(mag_r);
    end
    if (dp_cmd.acc_en) begin
      cand_dist_nxt = new_acc;
      acc_nxt       = dp_sts.is_last ? '0 : new_acc;
    end
    if (dp_cmd.append) begin
      wr_en    = 1'b1;
      wr_idx   = l2k_pkg::list_t'(fill_r);
      wr_dist  = new_acc;
      fill_nxt = fill_r + 1'b1;
    end
    if (dp_cmd.scan_clr) begin
      scan_nxt = '0;
    end
    if (dp_cmd.worst_step) begin
      // strict compare keeps the lowest slot among equal worst distances
      if (scan_r == '0 || rd_dist > worst_dist_r) begin
        worst_idx_nxt  = scan_r;
        worst_dist_nxt = rd_dist;
      end
      scan_nxt = scan_r + 1'b1;
    end
    if (dp_cmd.repl) begin
      wr_en = cand_dist_r < worst_dist_r;
    end
    if (dp_cmd.pick_clr) begin
      rank_nxt      = '0;
      scan_nxt      = '0;
      sel_found_nxt = 1'b0;
      emitted_nxt   = '0;
    end
    if (dp_cmd.pick_step) begin
      if (ent_ok && ent_better) begin
        sel_found_nxt = 1'b1;
        sel_idx_nxt   = scan_r;
        sel_dist_nxt  = rd_dist;
        sel_id_nxt    = rd_id;
      end
      scan_nxt = scan_r + 1'b1;
    end
    if (dp_cmd.show) begin
      out_beat_nxt.rank            = l2k_pkg::rank_t'(rank_r);
      out_beat_nxt.slot_valid      = sel_found_r;
      out_beat_nxt.result_id       = sel_found_r ? sel_id_r : '0;
      out_beat_nxt.result_distance = sel_found_r ? sel_dist_r : '0;
      out_beat_nxt.last_result     = dp_sts.rank_last;
      if (sel_found_r) begin
        emitted_nxt[sel_idx_r] = 1'b1;
      end
    end
    if (dp_cmd.next_rank) begin
      rank_nxt      = rank_r + 1'b1;
      scan_nxt      = '0;
      sel_found_nxt = 1'b0;
    end
    if (dp_cmd.finish_clr) begin
      fill_nxt = '0;
      acc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      acc_r       <= '0;
      scan_r      <= '0;
      rank_r      <= '0;
      sel_found_r <= 1'b0;
      emitted_r   <= '0;
    end else begin
      fill_r      <= fill_nxt;
      acc_r       <= acc_nxt;
      scan_r      <= scan_nxt;
      rank_r      <= rank_nxt;
      sel_found_r <= sel_found_nxt;
      emitted_r   <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    id_r         <= id_nxt;
    mag_r        <= mag_nxt;
    sq_r         <= sq_nxt;
    cand_dist_r  <= cand_dist_nxt;
    worst_idx_r  <= worst_idx_nxt;
    worst_dist_r <= worst_dist_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_dist_r   <= sel_dist_nxt;
    sel_id_r     <= sel_id_nxt;
    out_beat_r   <= out_beat_nxt;
    if (wr_en) begin
      ent_dist_r[wr_idx] <= wr_dist;
      ent_id_r[wr_idx]   <= wr_id;
    end
  end

  assign out_beat = out_beat_r;

endmodule

// ===== rtl/l2_distance_top_k_select.sv =====
// l2_distance_top_k_select.sv: top level, exact k-nearest selection by squared L2 distance
//
// Input channel (in_valid / in_stall / in_beat) takes one command per beat:
//   load query element, candidate element, or finish. Unused command code is dropped.
// A candidate element passes through query store read, difference, square and
//   accumulate steps (the multiply pipe is shared by all elements, one element
//   in flight).
// On a candidate's last element with a full list, the block scans the list for
//   its worst entry and replaces it if the new one is nearer.
// Finish emits BEST_COUNT beats on out_valid / out_stall / out_beat, sorted by
//   distance then id; each rank takes a selection scan over the list, and a
//   finish holds in_stall until the last rank is loaded.
// The result register stays loaded while the receiver stalls; the selection of
//   the next rank goes on, and only loading the following beat waits.
// After the last rank is loaded the block takes new items at once.
// Reset (rst_n low, synchronous) empties the list and clears the accumulator;
//   query store contents are not cleared and must be loaded before use.
module l2_distance_top_k_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  l2k_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output l2k_pkg::out_beat_t  out_beat
);

  l2k_pkg::dp_cmd_t dp_cmd;
  l2k_pkg::dp_sts_t dp_sts;

  l2k_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_beat.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  l2k_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts),
    .out_beat (out_beat)
  );

endmodule

// ===== bench/l2_distance_top_k_select_test.sv =====
// Self-checking bench for the squared-L2 top-k selector: predicts each ranked beat and checks it.
`timescale 1ns / 100ps

module l2_distance_top_k_select_test;
  import l2k_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned      CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned      HOLD_CYCLES  = 400;
  localparam int unsigned      DRAIN_CYCLES = 200;
  localparam int unsigned      MAX_REPORTS  = 10;
  // candidates use indices 0 .. USED_DIMS-1 and the last index only
  localparam int unsigned      USED_DIMS    = 16;

  typedef enum int unsigned {VEC_RANDOM, VEC_NEAR, VEC_REPEAT, VEC_EXACT} vec_kind_e;

  // Predicts the ranked list for every finish beat and checks what comes out.
  class knn_list_model;
    elem_t       query [VECTOR_DIM];
    dist_t       running_sum = '0;
    id_t         best_id [BEST_COUNT];
    dist_t       best_dist [BEST_COUNT];
    int unsigned filled = 0;
    out_beat_t   expected_ranks [$];
    int unsigned mismatches = 0;

    function void enter_list(id_t id, dist_t cand_dist);
      int unsigned i, worst;
      worst = 0;
      if (filled < BEST_COUNT) begin
        best_id[filled]   = id;
        best_dist[filled] = cand_dist;
        filled++;
        return;
      end
      for (i = 1; i < BEST_COUNT; i++)
        if (best_dist[i] > best_dist[worst]) worst = i;
      // strict compare: an equal newcomer loses to the entry already held
      if (cand_dist < best_dist[worst]) begin
        best_id[worst]   = id;
        best_dist[worst] = cand_dist;
      end
    endfunction

    function void take_item(in_beat_t b);
      elem_t       v;
      diff_t       wide_v, wide_q, gap;
      mag_t        mag;
      sq_t         sq;
      sum_t        total;
      id_t         sid [BEST_COUNT];
      dist_t       sdist [BEST_COUNT];
      out_beat_t   o;
      int unsigned i, j;
      case (b.cmd)
        CMD_LOAD: begin
          if (b.element_index < VECTOR_DIM)
            query[b.element_index] = b.element_value[ELEMENT_BITS-1:0];
        end
        CMD_CAND: begin
          if (b.element_index < VECTOR_DIM) begin
            v      = b.element_value[ELEMENT_BITS-1:0];
            wide_v = v;
            wide_q = query[b.element_index];
            gap    = wide_v - wide_q;
            mag    = gap[ELEMENT_BITS] ? mag_t'(-gap) : mag_t'(gap);
            sq     = sq_t'(mag) * sq_t'(mag);
            // index 0 restarts the sum, dropping any unfinished candidate
            if (b.element_index == 0) total = sum_t'(sq);
            else total = sum_t'(running_sum) + sum_t'(sq);
            if (total > sum_t'({DIST_W{1'b1}})) running_sum = {DIST_W{1'b1}};
            else running_sum = total[DIST_W-1:0];
            if (b.element_index == VECTOR_DIM - 1) begin
              enter_list(b.candidate_id, running_sum);
              running_sum = '0;
            end
          end
        end
        CMD_FINISH: begin
          for (i = 0; i < filled; i++) begin
            j = i;
            while (j > 0 && ((best_dist[i] < sdist[j-1]) ||
                             (best_dist[i] == sdist[j-1] && best_id[i] < sid[j-1]))) begin
              sid[j]   = sid[j-1];
              sdist[j] = sdist[j-1];
              j--;
            end
            sid[j]   = best_id[i];
            sdist[j] = best_dist[i];
          end
          for (i = 0; i < BEST_COUNT; i++) begin
            o.rank            = rank_t'(i);
            o.slot_valid      = (i < filled);
            o.result_id       = (i < filled) ? sid[i] : '0;
            o.result_distance = (i < filled) ? sdist[i] : '0;
            o.last_result     = (i == BEST_COUNT - 1);
            expected_ranks.push_back(o);
          end
          filled      = 0;
          running_sum = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (expected_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: rank %0d valid %0b id %h dist %h last %0b",
                   got.rank, got.slot_valid, got.result_id, got.result_distance,
                   got.last_result);
        return;
      end
      want = expected_ranks.pop_front();
      if (got.rank !== want.rank || got.slot_valid !== want.slot_valid ||
          got.result_id !== want.result_id || got.result_distance !== want.result_distance ||
          got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch want %0d %0b %h %h %0b got %0d %0b %h %h %0b",
                   want.rank, want.slot_valid, want.result_id, want.result_distance,
                   want.last_result, got.rank, got.slot_valid, got.result_id,
                   got.result_distance, got.last_result);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  knn_list_model book = new;
  elem_t         query_copy [VECTOR_DIM];
  elem_t         last_vec [VECTOR_DIM];
  int unsigned   src_idle_pct = 0;
  int unsigned   sink_stall_pct = 0;
  bit            hold_request = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   cycles = 0;

  l2_distance_top_k_select u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_result(out_beat);
  end

  // receiver: random stalls, or a long hold-off when asked for one
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // offer one beat from a falling edge; return at the falling edge after it is taken
  task automatic put(logic [CMD_W-1:0] c, idx_t i, logic signed [VAL_W-1:0] v, id_t id);
    in_beat_t b;
    b.cmd           = c;
    b.element_index = i;
    b.element_value = v;
    b.candidate_id  = id;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    book.take_item(b);
    @(negedge clk);
  endtask

  // short candidates: index 0, a few middle elements, then the last index; random unused, load and abandoned beats
  task automatic run_round(int unsigned vectors, bit hold_at_finish);
    vec_kind_e   kind;
    bit          scramble;
    elem_t       v;
    idx_t        k;
    int          t;
    int unsigned c, e, cut, len;
    id_t         tag;
    for (c = 0; c < vectors; c++) begin
      case ($urandom_range(9))
        0: put(CMD_UNUSED, idx_t'($urandom), elem_t'($urandom), $urandom);
        1: begin
          k = idx_t'($urandom);
          query_copy[k] = elem_t'($urandom);
          put(CMD_LOAD, k, query_copy[k], $urandom);
        end
        2: begin
          // abandoned candidate; the next one restarts at index 0
          cut = $urandom_range(2);
          for (e = 0; e <= cut; e++) put(CMD_CAND, idx_t'(e), elem_t'($urandom), $urandom);
        end
        default: ;
      endcase
      kind     = vec_kind_e'($urandom_range(3));
      scramble = ($urandom_range(7) == 0);
      tag      = ($urandom_range(3) == 0) ? id_t'($urandom_range(15)) : id_t'($urandom);
      len      = $urandom_range(5, 2);
      for (e = 0; e < len; e++) begin
        if (e == 0) k = '0;
        else if (e == len - 1) k = idx_t'(VECTOR_DIM - 1);
        else if (scramble) k = idx_t'($urandom_range(USED_DIMS - 1, 1));
        else k = idx_t'(e);
        case (kind)
          VEC_NEAR: begin
            t = int'(query_copy[k]) + int'($urandom_range(8)) - 4;
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            v = elem_t'(t);
          end
          VEC_REPEAT: v = last_vec[k];
          VEC_EXACT:  v = query_copy[k];
          default:    v = elem_t'($urandom);
        endcase
        last_vec[k] = v;
        put(CMD_CAND, k, v, (e == len - 1) ? tag : id_t'($urandom));
      end
    end
    if (hold_at_finish) hold_request = 1'b1;
    put(CMD_FINISH, idx_t'($urandom), elem_t'($urandom), $urandom);
  endtask

  initial begin
    int unsigned e, ph;
    int unsigned src_pct [4];
    int unsigned sink_pct [4];
    idx_t        k;
    src_pct  = '{0, 68, 0, 30};
    sink_pct = '{0, 0, 68, 30};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // every index a candidate uses is loaded first, so no read hits an unwritten element
    for (e = 0; e <= USED_DIMS; e++) begin
      k = (e == USED_DIMS) ? idx_t'(VECTOR_DIM - 1) : idx_t'(e);
      if (k == '0) query_copy[k] = 16'sh8000;
      else if (k == idx_t'(VECTOR_DIM - 1)) query_copy[k] = 16'sh7FFF;
      else query_copy[k] = elem_t'($urandom);
      last_vec[k] = query_copy[k];
      put(CMD_LOAD, k, query_copy[k], $urandom);
    end

    // directed: empty list, unused code, extreme distances, restart, tie on distance
    put(CMD_FINISH, '0, '0, '0);
    put(CMD_UNUSED, '1, 16'sh7FFF, 32'hFFFF_FFFF);
    put(CMD_CAND, idx_t'(VECTOR_DIM - 1), 16'sh8000, 32'h0000_0000);
    put(CMD_CAND, idx_t'(VECTOR_DIM - 1), 16'sh7FFF, 32'hFFFF_FFFF);
    put(CMD_CAND, '0, 16'sh7FFF, $urandom);
    put(CMD_CAND, '0, 16'sh8000, $urandom);
    put(CMD_CAND, idx_t'(VECTOR_DIM - 1), 16'sh7FFF, 32'd5);
    put(CMD_CAND, '0, 16'sh7FFF, $urandom);
    put(CMD_CAND, idx_t'(3), 16'sh0000, $urandom);
    put(CMD_FINISH, '1, 16'sh7FFF, 32'hFFFF_FFFF);
    put(CMD_CAND, idx_t'(5), 16'sh0000, $urandom);
    put(CMD_CAND, idx_t'(VECTOR_DIM - 1), 16'sh0000, 32'hA5A5_5A5A);
    put(CMD_FINISH, '0, '0, '0);

    // each idling mix: a short list, then a full one with replacements
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      run_round($urandom_range(3, 1), 1'b0);
      run_round($urandom_range(13, 11), 1'b0);
    end

    // long receiver hold-off on the finish while items keep coming
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_round(4, 1'b1);
    run_round(2, 1'b0);

    in_valid <= 1'b0;
    while (book.expected_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
